// ===== design/aopb_pkg.sv =====
// shared types, constants and helpers of the alpha-over pixel blend
// no dependencies; used by the pipeline parts, the top level and the testbench
package aopb_pkg;

   localparam int DIM_W = 13;
   localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
   localparam int CRD_W = 12;
   localparam int IDX_W = 24;
   localparam int NUM_W = 24;
   localparam int QUO_W = 8;
   localparam int LANES = 3;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = QUO_W / BITS_PER_STAGE;

   localparam int LANE_RED = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE = 2;

   typedef enum logic [1:0] {
      CSR_CLIP_WIDTH  = 2'd0,
      CSR_CLIP_HEIGHT = 2'd1,
      CSR_ROW_PITCH   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             in_clip;
      logic [IDX_W-1:0] word_index;
   } side_type;

   typedef logic [LANES-1:0][NUM_W-1:0] num_arr_type;
   typedef logic [LANES-1:0][QUO_W-1:0] quo_arr_type;

   function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : v;
   endfunction

endpackage

// ===== design/aopb_req_if.sv =====
// input channel of the alpha-over pixel blend: coordinate, destination pixel, source color
// depends on nothing
interface aopb_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [15:0] x_pos;
   logic signed [15:0] y_pos;
   logic [31:0]        dest_pixel;
   logic [7:0]         src_red;
   logic [7:0]         src_green;
   logic [7:0]         src_blue;
   logic [7:0]         src_alpha;
   logic [8:0]         weight;

   modport source (
      output valid, mode, x_pos, y_pos, dest_pixel,
      output src_red, src_green, src_blue, src_alpha, weight,
      input  ready
   );
   modport sink (
      input  valid, mode, x_pos, y_pos, dest_pixel,
      input  src_red, src_green, src_blue, src_alpha, weight,
      output ready
   );
endinterface

// ===== design/aopb_rsp_if.sv =====
// result channel of the alpha-over pixel blend: write enable, word index, blended pixel
// depends on nothing
interface aopb_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [23:0] word_index;
   logic [31:0] blended_pixel;

   modport source (
      output valid, write_enable, word_index, blended_pixel,
      input  ready
   );
   modport sink (
      input  valid, write_enable, word_index, blended_pixel,
      output ready
   );
endinterface

// ===== design/aopb_front.sv =====
// front end of the blend pipeline: clip test, alpha scaling, index and numerators
// depends on aopb_pkg and aopb_req_if
module aopb_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   aopb_req_if.sink                   req_if,
   input  logic [aopb_pkg::DIM_W-1:0] clip_w,
   input  logic [aopb_pkg::DIM_W-1:0] clip_h,
   input  logic [aopb_pkg::DIM_W-1:0] pitch,
   output logic                       out_valid,
   output aopb_pkg::side_type         out_side,
   output logic [15:0]                out_w,
   output aopb_pkg::num_arr_type      out_num
);

   // stage 1: clip test and scaled alpha
   logic                               s1_valid_ff;
   logic                               s1_inside_ff, s1_inside_in;
   logic [7:0]                         s1_a_ff, s1_a_in;
   logic [7:0]                         s1_d_ff;
   logic [aopb_pkg::LANES-1:0][7:0]    s1_cs_ff, s1_cs_in;
   logic [aopb_pkg::LANES-1:0][7:0]    s1_cd_ff, s1_cd_in;
   logic [aopb_pkg::CRD_W-1:0]         s1_x_ff, s1_y_ff;
   logic [aopb_pkg::DIM_W-1:0]         s1_pitch_ff;
   logic [16:0]                        wprod;

   // stage 2: index and first products
   logic                               s2_valid_ff;
   aopb_pkg::side_type                 s2_side_ff, s2_side_in;
   logic [15:0]                        s2_ma_ff, s2_ma_in;
   logic [15:0]                        s2_md_ff, s2_md_in;
   logic [7:0]                         s2_na_ff, s2_na_in;
   logic [aopb_pkg::LANES-1:0][15:0]   s2_csa_ff, s2_csa_in;
   logic [aopb_pkg::LANES-1:0][15:0]   s2_cdd_ff, s2_cdd_in;

   // stage 3: weight and channel numerators
   logic                               s3_valid_ff;
   aopb_pkg::side_type                 s3_side_ff;
   logic [15:0]                        s3_w_ff, s3_w_in;
   aopb_pkg::num_arr_type              s3_num_ff, s3_num_in;

   assign req_if.ready = adv;

   always_comb begin
      wprod = {9'd0, req_if.src_alpha} * {8'd0, req_if.weight};
      s1_inside_in = !req_if.x_pos[15] && !req_if.y_pos[15]
         && ($unsigned(req_if.x_pos) < {3'd0, clip_w})
         && ($unsigned(req_if.y_pos) < {3'd0, clip_h});
      if (!req_if.mode) begin
         s1_a_in = req_if.src_alpha;
      end else if (wprod[16]) begin
         s1_a_in = 8'hFF;
      end else begin
         s1_a_in = wprod[15:8];
      end
      s1_cs_in[aopb_pkg::LANE_RED]   = req_if.src_red;
      s1_cs_in[aopb_pkg::LANE_GREEN] = req_if.src_green;
      s1_cs_in[aopb_pkg::LANE_BLUE]  = req_if.src_blue;
      s1_cd_in[aopb_pkg::LANE_RED]   = req_if.dest_pixel[7:0];
      s1_cd_in[aopb_pkg::LANE_GREEN] = req_if.dest_pixel[15:8];
      s1_cd_in[aopb_pkg::LANE_BLUE]  = req_if.dest_pixel[23:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_if.valid;
      end
      if (adv) begin
         s1_inside_ff <= s1_inside_in;
         s1_a_ff      <= s1_a_in;
         s1_d_ff      <= req_if.dest_pixel[31:24];
         s1_cs_ff     <= s1_cs_in;
         s1_cd_ff     <= s1_cd_in;
         s1_x_ff      <= req_if.x_pos[aopb_pkg::CRD_W-1:0];
         s1_y_ff      <= req_if.y_pos[aopb_pkg::CRD_W-1:0];
         s1_pitch_ff  <= pitch;
      end
   end

   always_comb begin
      s2_side_in.in_clip    = s1_inside_ff;
      s2_side_in.word_index = ({12'd0, s1_y_ff} * {11'd0, s1_pitch_ff}) + {12'd0, s1_x_ff};
      s2_na_in = 8'hFF - s1_a_ff;
      s2_ma_in = {s1_a_ff, 8'd0} - {8'd0, s1_a_ff};
      s2_md_in = {8'd0, s1_d_ff} * {8'd0, s2_na_in};
      for (int l = 0; l < aopb_pkg::LANES; l++) begin
         s2_csa_in[l] = {8'd0, s1_cs_ff[l]} * {8'd0, s1_a_ff};
         s2_cdd_in[l] = {8'd0, s1_cd_ff[l]} * {8'd0, s1_d_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_side_ff <= s2_side_in;
         s2_na_ff   <= s2_na_in;
         s2_ma_ff   <= s2_ma_in;
         s2_md_ff   <= s2_md_in;
         s2_csa_ff  <= s2_csa_in;
         s2_cdd_ff  <= s2_cdd_in;
      end
   end

   // num = cs*a*255 + cd*d*(255-a); never above 255*w
   always_comb begin
      s3_w_in = s2_ma_ff + s2_md_ff;
      for (int l = 0; l < aopb_pkg::LANES; l++) begin
         s3_num_in[l] = ({s2_csa_ff[l], 8'd0} - {8'd0, s2_csa_ff[l]})
            + ({8'd0, s2_cdd_ff[l]} * {16'd0, s2_na_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s3_side_ff <= s2_side_ff;
         s3_w_ff    <= s3_w_in;
         s3_num_ff  <= s3_num_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_side  = s3_side_ff;
   assign out_w     = s3_w_ff;
   assign out_num   = s3_num_ff;

endmodule

// ===== design/aopb_div.sv =====
// pipelined restoring divider: three channel quotients by the shared weight, two bits a stage
// also forms output alpha as weight/255 by reciprocal multiply; depends on aopb_pkg
module aopb_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  aopb_pkg::side_type    in_side,
   input  logic [15:0]           in_w,
   input  aopb_pkg::num_arr_type in_num,
   output logic                  out_valid,
   output aopb_pkg::side_type    out_side,
   output logic [7:0]            out_ao,
   output logic                  out_wzero,
   output aopb_pkg::quo_arr_type out_quo
);

   localparam int STG = aopb_pkg::DIV_STAGES;

   logic [STG-1:0]        v_ff;
   aopb_pkg::side_type    side_ff [STG];
   logic [15:0]           w_ff    [STG];
   logic [7:0]            ao_ff   [STG];
   logic [7:0]            ao_in   [STG];
   aopb_pkg::num_arr_type rem_ff  [STG];
   aopb_pkg::num_arr_type rem_in  [STG];
   aopb_pkg::quo_arr_type quo_ff  [STG];
   aopb_pkg::quo_arr_type quo_in  [STG];

   for (genvar s = 0; s < STG; s++) begin : g_stage
      localparam int TOP_BIT = aopb_pkg::QUO_W - 1 - aopb_pkg::BITS_PER_STAGE * s;

      logic                  v_src;
      aopb_pkg::side_type    side_src;
      logic [15:0]           w_src;
      aopb_pkg::num_arr_type rem_src;
      aopb_pkg::quo_arr_type quo_src;

      if (s == 0) begin : g_head
         logic [31:0] recip;
         // floor(w/255) is exact as (w*0x8081)>>23 over 16 bits
         assign recip    = {16'd0, in_w} * 32'h0000_8081;
         assign ao_in[s] = recip[30:23];
         assign v_src    = in_valid;
         assign side_src = in_side;
         assign w_src    = in_w;
         assign rem_src  = in_num;
         assign quo_src  = '0;
      end else begin : g_body
         assign ao_in[s] = ao_ff[s-1];
         assign v_src    = v_ff[s-1];
         assign side_src = side_ff[s-1];
         assign w_src    = w_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign quo_src  = quo_ff[s-1];
      end

      always_comb begin
         logic [aopb_pkg::NUM_W-1:0] r;
         logic [aopb_pkg::NUM_W-1:0] dv;
         logic [aopb_pkg::QUO_W-1:0] q;
         for (int l = 0; l < aopb_pkg::LANES; l++) begin
            r = rem_src[l];
            q = quo_src[l];
            for (int k = 0; k < aopb_pkg::BITS_PER_STAGE; k++) begin
               dv = {8'd0, w_src} << (TOP_BIT - k);
               if (r >= dv) begin
                  r = r - dv;
                  q[TOP_BIT-k] = 1'b1;
               end
            end
            rem_in[s][l] = r;
            quo_in[s][l] = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_src;
         end
         if (adv) begin
            side_ff[s] <= side_src;
            w_ff[s]    <= w_src;
            ao_ff[s]   <= ao_in[s];
            rem_ff[s]  <= rem_in[s];
            quo_ff[s]  <= quo_in[s];
         end
      end
   end

   assign out_valid = v_ff[STG-1];
   assign out_side  = side_ff[STG-1];
   assign out_ao    = ao_ff[STG-1];
   assign out_wzero = (w_ff[STG-1] == 16'd0);
   assign out_quo   = quo_ff[STG-1];

endmodule

// ===== design/alpha_over_pixel_blend.sv =====
// top level of the alpha-over pixel blend: config registers, pipeline and result register
// depends on aopb_pkg, aopb_req_if, aopb_rsp_if, aopb_front and aopb_div
//
// One input word gives one result word, which the result register shows on the result
// port. There are eight register stages, the first loaded at acceptance: three front
// stages (clip test and alpha scaling, index multiply and first products, weight and
// channel numerators), four divider stages that each resolve two quotient bits for all
// three channels, and the result register. Throughput is one word per clock while the
// result side takes words. When a result waits and rsp ready is low, the whole pipeline
// holds and req ready drops; nothing is lost or repeated. Coordinates outside the clip
// area give an all-zero result; when both alphas are zero the pixel is zero. Register
// values above 4096 act as 4096. Config writes take effect for words accepted afterwards.
module alpha_over_pixel_blend (
   input  logic                       clock,
   input  logic                       reset,
   aopb_req_if.sink                   req_if,
   aopb_rsp_if.source                 rsp_if,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_index,
   input  logic [aopb_pkg::DIM_W-1:0] csr_wdata
);

   // config registers
   logic [aopb_pkg::DIM_W-1:0] clip_width_ff;
   logic [aopb_pkg::DIM_W-1:0] clip_height_ff;
   logic [aopb_pkg::DIM_W-1:0] row_pitch_ff;

   // pipeline advance: the whole pipe moves unless a result is stuck at the output
   logic                       adv;

   // front to divider
   logic                       fr_valid;
   aopb_pkg::side_type         fr_side;
   logic [15:0]                fr_w;
   aopb_pkg::num_arr_type      fr_num;

   // divider to result register
   logic                       dv_valid;
   aopb_pkg::side_type         dv_side;
   logic [7:0]                 dv_ao;
   logic                       dv_wzero;
   aopb_pkg::quo_arr_type      dv_quo;

   // result register
   logic                       rsp_valid_ff;
   logic                       rsp_we_ff, rsp_we_in;
   logic [aopb_pkg::IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [31:0]                rsp_pixel_ff, rsp_pixel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_width_ff  <= 13'd640;
         clip_height_ff <= 13'd480;
         row_pitch_ff   <= 13'd640;
      end else if (csr_wr_en) begin
         unique case (aopb_pkg::csr_index_type'(csr_index))
            aopb_pkg::CSR_CLIP_WIDTH:  clip_width_ff  <= csr_wdata;
            aopb_pkg::CSR_CLIP_HEIGHT: clip_height_ff <= csr_wdata;
            aopb_pkg::CSR_ROW_PITCH:   row_pitch_ff   <= csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   assign adv = !rsp_valid_ff || rsp_if.ready;

   aopb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_if    (req_if),
      .clip_w    (aopb_pkg::limit_dim(clip_width_ff)),
      .clip_h    (aopb_pkg::limit_dim(clip_height_ff)),
      .pitch     (aopb_pkg::limit_dim(row_pitch_ff)),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_w     (fr_w),
      .out_num   (fr_num)
   );

   aopb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_w      (fr_w),
      .in_num    (fr_num),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_ao    (dv_ao),
      .out_wzero (dv_wzero),
      .out_quo   (dv_quo)
   );

   // outside clip zeroes every field; zero weight zeroes only the pixel
   always_comb begin
      rsp_we_in    = dv_side.in_clip;
      rsp_index_in = dv_side.in_clip ? dv_side.word_index : '0;
      if (dv_side.in_clip && !dv_wzero) begin
         rsp_pixel_in = {dv_ao, dv_quo[aopb_pkg::LANE_BLUE],
                         dv_quo[aopb_pkg::LANE_GREEN], dv_quo[aopb_pkg::LANE_RED]};
      end else begin
         rsp_pixel_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
      if (adv) begin
         rsp_we_ff    <= rsp_we_in;
         rsp_index_ff <= rsp_index_in;
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.write_enable  = rsp_we_ff;
   assign rsp_if.word_index    = rsp_index_ff;
   assign rsp_if.blended_pixel = rsp_pixel_ff;

endmodule

// ===== verif/alpha_over_pixel_blend_tb.sv =====
// self-checking testbench of the alpha-over pixel blend: directed and random pixel words,
// several clip and pitch settings, random stalls on both channels, in-order result checking
// depends on aopb_pkg, aopb_req_if, aopb_rsp_if and alpha_over_pixel_blend
module alpha_over_pixel_blend_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [aopb_pkg::DIM_W-1:0] dim_type;

   // one pixel word as it enters the block
   typedef struct {
      logic               mode;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic [31:0]        dest_pixel;
      logic [7:0]         src_red;
      logic [7:0]         src_green;
      logic [7:0]         src_blue;
      logic [7:0]         src_alpha;
      logic [8:0]         weight;
   } pixel_word_type;

   // one result word as it leaves the block
   typedef struct {
      logic        write_enable;
      logic [23:0] word_index;
      logic [31:0] blended_pixel;
   } blend_word_type;

   // predicts the blend of every accepted pixel word and checks results in order
   class blend_scoreboard;
      dim_type          clip_w;
      dim_type          clip_h;
      dim_type          pitch;
      blend_word_type   pending_blends[$];
      int unsigned      errors;
      int unsigned      seen;

      function new();
         clip_w = 13'd640;
         clip_h = 13'd480;
         pitch  = 13'd640;
         errors = 0;
         seen   = 0;
      endfunction

      function void set_reg(aopb_pkg::csr_index_type idx, dim_type val);
         case (idx)
            aopb_pkg::CSR_CLIP_WIDTH:  clip_w = val;
            aopb_pkg::CSR_CLIP_HEIGHT: clip_h = val;
            aopb_pkg::CSR_ROW_PITCH:   pitch = val;
            default: ;
         endcase
      endfunction

      function int unsigned dim_or_max(dim_type v);
         return (v > aopb_pkg::MAX_DIM) ? int'(aopb_pkg::MAX_DIM) : int'(v);
      endfunction

      function blend_word_type blend(pixel_word_type p);
         blend_word_type    o;
         int                x;
         int                y;
         int unsigned       cw;
         int unsigned       ch;
         int unsigned       pw;
         int unsigned       a;
         int unsigned       d;
         int unsigned       wsum;
         int unsigned       ao;
         longint unsigned   num;
         longint unsigned   q;
         logic [7:0]        src_c [3];
         logic [7:0]        out_c [3];
         o.write_enable  = 1'b0;
         o.word_index    = '0;
         o.blended_pixel = '0;
         x  = int'(p.x_pos);
         y  = int'(p.y_pos);
         cw = dim_or_max(clip_w);
         ch = dim_or_max(clip_h);
         pw = dim_or_max(pitch);
         if (x < 0 || y < 0 || x >= int'(cw) || y >= int'(ch))
            return o;
         o.write_enable = 1'b1;
         o.word_index   = 24'(longint'(y) * pw + x);
         a = 32'(p.src_alpha);
         if (p.mode) begin
            a = (int'(p.src_alpha) * int'(p.weight)) >> 8;
            if (a > 255)
               a = 255;
         end
         d    = 32'(p.dest_pixel[31:24]);
         wsum = a * 255 + d * (255 - a);
         if (wsum == 0)
            return o;
         ao = wsum / 255;
         src_c[0] = p.src_red;
         src_c[1] = p.src_green;
         src_c[2] = p.src_blue;
         for (int i = 0; i < 3; i++) begin
            num = longint'(src_c[i]) * a * 255 +
                  longint'(p.dest_pixel[8*i +: 8]) * d * (255 - a);
            q = num / wsum;
            out_c[i] = (q > 255) ? 8'hff : 8'(q);
         end
         o.blended_pixel = {ao[7:0], out_c[2], out_c[1], out_c[0]};
         return o;
      endfunction

      function void note_word(pixel_word_type p);
         pending_blends.push_back(blend(p));
      endfunction

      function int pending();
         return pending_blends.size();
      endfunction

      task report_mismatch(string what);
         $display("ERROR at %0t: result %0d: %s", $realtime, seen, what);
         errors++;
      endtask

      task check_word(blend_word_type got);
         blend_word_type want;
         if (pending_blends.size() == 0) begin
            report_mismatch("result word with nothing pending");
            seen++;
            return;
         end
         want = pending_blends.pop_front();
         if (got.write_enable !== want.write_enable)
            report_mismatch($sformatf("write_enable got %b want %b",
                                      got.write_enable, want.write_enable));
         if (got.word_index !== want.word_index)
            report_mismatch($sformatf("word_index got %h want %h",
                                      got.word_index, want.word_index));
         if (got.blended_pixel !== want.blended_pixel)
            report_mismatch($sformatf("blended_pixel got %h want %h",
                                      got.blended_pixel, want.blended_pixel));
         seen++;
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [1:0]       csr_index;
   dim_type          csr_wdata;
   bit               no_gaps;
   blend_word_type   rsp_seen;
   blend_scoreboard  sb;

   aopb_req_if req_ch ();
   aopb_rsp_if rsp_ch ();

   alpha_over_pixel_blend i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch.sink),
      .rsp_if    (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop with a failure message, far beyond what about 1250 words at the worst stall
   // mix need
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // result side stalls in about 18 percent of cycles, never during a steady stretch
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = no_gaps || ($urandom_range(0, 99) >= 18);
      end
   end

   // every accepted result word goes to the scoreboard, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         rsp_seen.write_enable  = rsp_ch.write_enable;
         rsp_seen.word_index    = rsp_ch.word_index;
         rsp_seen.blended_pixel = rsp_ch.blended_pixel;
         sb.check_word(rsp_seen);
      end
   end

   // config write while idle; entered and left at a falling edge
   task automatic write_reg(aopb_pkg::csr_index_type idx, dim_type val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   // drop valid and hold off until every pending blend has come back
   task automatic wait_drained(int settle);
      req_ch.valid = 1'b0;
      while (sb.pending() > 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // offer one pixel word, with random idle cycles ahead of it; valid stays high after
   // acceptance so back-to-back words see no bubble
   task automatic send_pixel(pixel_word_type p);
      while (!no_gaps && $urandom_range(0, 99) < 18) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.mode       = p.mode;
      req_ch.x_pos      = p.x_pos;
      req_ch.y_pos      = p.y_pos;
      req_ch.dest_pixel = p.dest_pixel;
      req_ch.src_red    = p.src_red;
      req_ch.src_green  = p.src_green;
      req_ch.src_blue   = p.src_blue;
      req_ch.src_alpha  = p.src_alpha;
      req_ch.weight     = p.weight;
      do
         @(posedge clock);
      while (!req_ch.ready);
      sb.note_word(p);
      @(negedge clock);
   endtask

   function automatic pixel_word_type make_pixel(logic m, int x, int y, logic [31:0] dest,
                                                 logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b, logic [7:0] a,
                                                 logic [8:0] wt);
      pixel_word_type p;
      p.mode       = m;
      p.x_pos      = 16'(x);
      p.y_pos      = 16'(y);
      p.dest_pixel = dest;
      p.src_red    = r;
      p.src_green  = g;
      p.src_blue   = b;
      p.src_alpha  = a;
      p.weight     = wt;
      return p;
   endfunction

   // alpha biased toward fully clear and fully opaque
   function automatic logic [7:0] alpha_sample();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         return 8'h00;
      else if (pick < 35)
         return 8'hff;
      return 8'($urandom);
   endfunction

   // mostly inside the clip area, some on its borders, the rest anywhere in 16 bits
   function automatic pixel_word_type random_pixel();
      pixel_word_type p;
      int unsigned cw;
      int unsigned ch;
      int unsigned pick;
      int          x;
      int          y;
      cw   = sb.dim_or_max(sb.clip_w);
      ch   = sb.dim_or_max(sb.clip_h);
      pick = $urandom_range(0, 99);
      if (pick < 72 && cw > 0 && ch > 0) begin
         x = $urandom_range(0, cw - 1);
         y = $urandom_range(0, ch - 1);
      end else if (pick < 86) begin
         x = $urandom_range(0, 1) ? int'(cw) : int'(cw) - 1;
         y = $urandom_range(0, 1) ? int'(ch) : int'(ch) - 1;
         if ($urandom_range(0, 1) && cw > 0)
            x = $urandom_range(0, cw - 1);
      end else begin
         x = $urandom;
         y = $urandom;
      end
      p = make_pixel(1'($urandom_range(0, 1)), x, y, $urandom, 8'($urandom), 8'($urandom),
                     8'($urandom), alpha_sample(), '0);
      p.dest_pixel[31:24] = alpha_sample();
      pick = $urandom_range(0, 99);
      if (pick < 60)
         p.weight = 9'($urandom_range(0, 256));
      else if (pick < 75)
         p.weight = 9'd256;
      else if (pick < 85)
         p.weight = 9'd0;
      else
         p.weight = 9'($urandom_range(0, 511));
      return p;
   endfunction

   // one setting of the three registers followed by random words
   task automatic run_phase(int unsigned cw, int unsigned ch, int unsigned pw,
                            int count, bit steady);
      wait_drained(12);
      write_reg(aopb_pkg::CSR_CLIP_WIDTH, dim_type'(cw));
      write_reg(aopb_pkg::CSR_CLIP_HEIGHT, dim_type'(ch));
      write_reg(aopb_pkg::CSR_ROW_PITCH, dim_type'(pw));
      no_gaps = steady;
      for (int n = 0; n < count; n++) begin
         // sender holds off once per phase until the pipeline is empty
         if (n == count / 2)
            wait_drained(0);
         send_pixel(random_pixel());
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      sb                = new();
      no_gaps           = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = aopb_pkg::CSR_CLIP_WIDTH;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.mode       = 1'b0;
      req_ch.x_pos      = '0;
      req_ch.y_pos      = '0;
      req_ch.dest_pixel = '0;
      req_ch.src_red    = '0;
      req_ch.src_green  = '0;
      req_ch.src_blue   = '0;
      req_ch.src_alpha  = '0;
      req_ch.weight     = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed words under the reset setting 640 x 480, pitch 640
      // both alphas zero gives a zero pixel
      send_pixel(make_pixel(1'b0, 0, 0, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0));
      // far corner, everything at full scale
      send_pixel(make_pixel(1'b0, 639, 479, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 8'hff,
                            9'h1ff));
      send_pixel(make_pixel(1'b0, 639, 0, 32'h8040_2010, 8'h12, 8'h34, 8'h56, 8'h80, 9'd0));
      send_pixel(make_pixel(1'b0, 0, 479, 32'h7f00_ff00, 8'hff, 8'h00, 8'hff, 8'h7f, 9'd0));
      // just outside on each side, and the coordinate extremes
      send_pixel(make_pixel(1'b0, 640, 0, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 8'hff, 9'd0));
      send_pixel(make_pixel(1'b0, 0, 480, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 8'hff, 9'd0));
      send_pixel(make_pixel(1'b0, -1, 5, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 8'hff, 9'd0));
      send_pixel(make_pixel(1'b0, 5, -32768, 32'hff00_0000, 8'h01, 8'h02, 8'h03, 8'hff,
                            9'd0));
      send_pixel(make_pixel(1'b1, 32767, 32767, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 8'hff,
                            9'd256));
      send_pixel(make_pixel(1'b0, -32768, -1, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 8'hff,
                            9'd0));
      // clear source over opaque destination leaves the destination
      send_pixel(make_pixel(1'b0, 100, 200, 32'hff12_3456, 8'hff, 8'hff, 8'hff, 8'h00, 9'd0));
      // opaque source over clear destination
      send_pixel(make_pixel(1'b0, 101, 200, 32'h00ff_ffff, 8'h9a, 8'hbc, 8'hde, 8'hff, 9'd0));
      // half over half
      send_pixel(make_pixel(1'b0, 102, 200, 32'h80c0_4020, 8'h10, 8'hf0, 8'h80, 8'h80, 9'd0));
      send_pixel(make_pixel(1'b0, 103, 200, 32'h01ff_ffff, 8'h00, 8'h00, 8'h00, 8'h01, 9'd0));
      // weighted: zero weight over clear destination gives zero alpha on both sides
      send_pixel(make_pixel(1'b1, 104, 201, 32'h00ab_cdef, 8'hff, 8'hff, 8'hff, 8'hff, 9'd0));
      send_pixel(make_pixel(1'b1, 105, 201, 32'h4020_40ff, 8'h11, 8'h22, 8'h33, 8'hc8,
                            9'd256));
      // weight above full scale saturates the alpha
      send_pixel(make_pixel(1'b1, 106, 201, 32'h80ff_0080, 8'h00, 8'h80, 8'hff, 8'hff,
                            9'h1ff));
      send_pixel(make_pixel(1'b1, 107, 201, 32'h2000_0000, 8'hff, 8'h00, 8'h7f, 8'hff,
                            9'd300));
      // scaled alpha truncates to zero
      send_pixel(make_pixel(1'b1, 108, 201, 32'h00ff_ffff, 8'hff, 8'hff, 8'hff, 8'h01,
                            9'd128));
      send_pixel(make_pixel(1'b1, 109, 202, 32'hff00_ff00, 8'hff, 8'h00, 8'hff, 8'h80,
                            9'd128));

      // random words over a range of settings, extremes first
      run_phase(640, 480, 640, 150, 1'b0);
      run_phase(1, 1, 1, 120, 1'b0);
      // long stretch with no stalls on either side
      run_phase(4096, 4096, 4096, 170, 1'b1);
      // register values above the maximum act as the maximum
      run_phase(8191, 5000, 4097, 150, 1'b0);
      // zero clip width: nothing is ever written
      run_phase(0, 100, 20, 60, 1'b0);
      // zero pitch: index is just x
      run_phase(37, 29, 0, 150, 1'b0);
      run_phase(4096, 1, 8191, 120, 1'b0);
      run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 4096),
                150, 1'b0);
      run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 8191),
                150, 1'b0);

      // drain, then a few cycles to catch any stray result word
      wait_drained(16);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
